// ===== src/arlp_pkg.sv =====
package arlp_pkg;

    // Reply status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_DEV_ERR  = 3'd1;
    localparam logic [2:0] STATUS_TOO_LONG = 3'd2;
    localparam logic [2:0] STATUS_TOO_SHORT = 3'd3;
    localparam logic [2:0] STATUS_TIMEOUT  = 3'd4;

    // number_found codes
    localparam logic [1:0] FOUND_NONE   = 2'd0;
    localparam logic [1:0] FOUND_SIGN   = 2'd1;
    localparam logic [1:0] FOUND_NUMBER = 2'd2;

    // Characters of interest
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_T       = 8'h54;
    localparam logic [7:0] CHAR_P       = 8'h50;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    localparam logic [7:0] LINE_LIMIT_RESET = 8'd255;
    localparam logic [7:0] COUNT_MAX        = 8'd255;

    // Magnitude saturation
    localparam logic [63:0] MAG_LIMIT    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_STEP_MAX = 64'd922337203685477580;
    localparam logic [63:0] POS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

    // Output tdata layout
    localparam int OUT_TDATA_W = 80;

    // Classified byte, front to back
    typedef struct packed {
        logic       timeout;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_star;
        logic       is_tp;
        logic       is_sign;
        logic       is_minus;
        logic       is_nul;
        logic       is_newline;
    } class_t;

endpackage

// ===== src/arlp_front.sv =====
module arlp_front
(
    input  logic [7:0]      rx_byte,
    input  logic            rx_timeout,
    output arlp_pkg::class_t cls
);

    logic       digit_hit;
    logic [7:0] digit_off;

    assign digit_hit = (rx_byte >= arlp_pkg::CHAR_ZERO) && (rx_byte <= arlp_pkg::CHAR_NINE);
    assign digit_off = rx_byte - arlp_pkg::CHAR_ZERO;

    // Classify one received byte; a timeout masks every byte class but is_minus
    always_comb
    begin
        cls.timeout    = rx_timeout;
        cls.is_digit   = !rx_timeout && digit_hit;
        cls.digit      = digit_off[3:0];
        cls.is_star    = !rx_timeout && (rx_byte == arlp_pkg::CHAR_STAR);
        cls.is_tp      = !rx_timeout && ((rx_byte == arlp_pkg::CHAR_T) ||
                                         (rx_byte == arlp_pkg::CHAR_P));
        cls.is_sign    = !rx_timeout && ((rx_byte == arlp_pkg::CHAR_MINUS) ||
                                         (rx_byte == arlp_pkg::CHAR_PLUS));
        cls.is_minus   = (rx_byte == arlp_pkg::CHAR_MINUS);
        cls.is_nul     = !rx_timeout && (rx_byte == arlp_pkg::CHAR_NUL);
        cls.is_newline = !rx_timeout && (rx_byte == arlp_pkg::CHAR_NEWLINE);
    end

endmodule

// ===== src/arlp_queue.sv =====
module arlp_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  arlp_pkg::class_t push_data,
    output logic             not_full,
    input  logic             pop,
    output arlp_pkg::class_t pop_data,
    output logic             not_empty
);

    arlp_pkg::class_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/arlp_back.sv =====
module arlp_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             line_limit_we,
    input  logic [7:0]       line_limit_wdata,
    input  logic             q_valid,
    input  arlp_pkg::class_t q_data,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [arlp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Number scan phases
    localparam logic [1:0] PH_SEEK   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_CLOSED = 2'd3;

    logic [7:0]  line_limit_reg;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic        ack_seen_reg, ack_seen_next;
    logic [1:0]  scan_phase_reg, scan_phase_next;
    logic        is_negative_reg, is_negative_next;
    logic [63:0] accumulator_reg, accumulator_next;
    logic        warn_flag_reg, warn_flag_next;
    logic        digits_seen_reg, digits_seen_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [7:0]  out_length_reg, out_length_next;
    logic [63:0] out_mag_reg, out_mag_next;
    logic        out_neg_reg, out_neg_next;
    logic [1:0]  out_found_reg, out_found_next;
    logic        out_warn_reg, out_warn_next;

    logic [7:0]  count_inc;
    logic [63:0] acc_times_ten;
    logic [63:0] acc_digit;
    logic        acc_big;
    logic        line_done;
    logic        emits;
    logic        out_free;
    logic [63:0] value;

    // Digit accumulate: acc*10 + d with saturation at 2^63
    always_comb
    begin
        acc_big       = accumulator_reg > arlp_pkg::MAG_STEP_MAX;
        acc_times_ten = (accumulator_reg << 3) + (accumulator_reg << 1) +
                        {60'd0, q_data.digit};
        if (acc_big || (acc_times_ten > arlp_pkg::MAG_LIMIT))
            acc_digit = arlp_pkg::MAG_LIMIT;
        else
            acc_digit = acc_times_ten;
    end

    // Per-byte line state update
    always_comb
    begin
        count_inc        = (byte_count_reg != arlp_pkg::COUNT_MAX) ?
                           byte_count_reg + 8'd1 : byte_count_reg;
        byte_count_next  = count_inc;
        ack_seen_next    = ack_seen_reg | q_data.is_star;
        warn_flag_next   = warn_flag_reg | ((count_inc == 8'd2) && q_data.is_tp);
        scan_phase_next  = scan_phase_reg;
        is_negative_next = is_negative_reg;
        accumulator_next = accumulator_reg;
        digits_seen_next = digits_seen_reg;

        unique case (scan_phase_reg)
            PH_SEEK:
            begin
                if (q_data.is_digit)
                begin
                    accumulator_next = acc_digit;
                    digits_seen_next = 1'b1;
                    scan_phase_next  = PH_DIGITS;
                end
                else if (q_data.is_nul)
                begin
                    scan_phase_next = PH_CLOSED;
                end
                else if (q_data.is_sign)
                begin
                    is_negative_next = q_data.is_minus;
                    scan_phase_next  = PH_SIGN;
                end
            end
            PH_SIGN, PH_DIGITS:
            begin
                if (q_data.is_digit)
                begin
                    accumulator_next = acc_digit;
                    digits_seen_next = 1'b1;
                    scan_phase_next  = PH_DIGITS;
                end
                else
                begin
                    scan_phase_next = PH_CLOSED;
                end
            end
            PH_CLOSED:
            begin
            end
        endcase
    end

    // Line end and result fields
    always_comb
    begin
        line_done = q_data.is_newline || (count_inc >= line_limit_reg);
        emits     = q_data.timeout || line_done;
        out_free  = !out_valid_reg || m_tready;
        q_pop     = q_valid && (!emits || out_free);

        out_length_next = 8'd0;
        if (q_data.timeout)
            out_status_next = arlp_pkg::STATUS_TIMEOUT;
        else if (count_inc >= line_limit_reg)
            out_status_next = arlp_pkg::STATUS_TOO_LONG;
        else if (count_inc < 8'd2)
            out_status_next = arlp_pkg::STATUS_TOO_SHORT;
        else if (ack_seen_next)
        begin
            out_status_next = arlp_pkg::STATUS_OK;
            out_length_next = count_inc - 8'd1;
        end
        else
            out_status_next = arlp_pkg::STATUS_DEV_ERR;

        if (q_data.timeout)
        begin
            out_mag_next  = accumulator_reg;
            out_neg_next  = is_negative_reg;
            out_warn_next = warn_flag_reg;
            if (digits_seen_reg)
                out_found_next = arlp_pkg::FOUND_NUMBER;
            else if (scan_phase_reg != PH_SEEK)
                out_found_next = arlp_pkg::FOUND_SIGN;
            else
                out_found_next = arlp_pkg::FOUND_NONE;
        end
        else
        begin
            out_mag_next  = accumulator_next;
            out_neg_next  = is_negative_next;
            out_warn_next = warn_flag_next;
            if (digits_seen_next)
                out_found_next = arlp_pkg::FOUND_NUMBER;
            else if (scan_phase_next != PH_SEEK)
                out_found_next = arlp_pkg::FOUND_SIGN;
            else
                out_found_next = arlp_pkg::FOUND_NONE;
        end

        if (q_pop && emits)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Config register and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg  <= arlp_pkg::LINE_LIMIT_RESET;
            byte_count_reg  <= 8'd0;
            ack_seen_reg    <= 1'b0;
            scan_phase_reg  <= PH_SEEK;
            is_negative_reg <= 1'b0;
            accumulator_reg <= 64'd0;
            warn_flag_reg   <= 1'b0;
            digits_seen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (line_limit_we)
                line_limit_reg <= line_limit_wdata;
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                if (emits)
                begin
                    byte_count_reg  <= 8'd0;
                    ack_seen_reg    <= 1'b0;
                    scan_phase_reg  <= PH_SEEK;
                    is_negative_reg <= 1'b0;
                    accumulator_reg <= 64'd0;
                    warn_flag_reg   <= 1'b0;
                    digits_seen_reg <= 1'b0;
                end
                else
                begin
                    byte_count_reg  <= byte_count_next;
                    ack_seen_reg    <= ack_seen_next;
                    scan_phase_reg  <= scan_phase_next;
                    is_negative_reg <= is_negative_next;
                    accumulator_reg <= accumulator_next;
                    warn_flag_reg   <= warn_flag_next;
                    digits_seen_reg <= digits_seen_next;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop && emits)
        begin
            out_status_reg <= out_status_next;
            out_length_reg <= out_length_next;
            out_mag_reg    <= out_mag_next;
            out_neg_reg    <= out_neg_next;
            out_found_reg  <= out_found_next;
            out_warn_reg   <= out_warn_next;
        end
    end

    // Signed value from magnitude; zero magnitude covers "no digits"
    always_comb
    begin
        if (out_neg_reg)
            value = 64'd0 - out_mag_reg;
        else if (out_mag_reg[63])
            value = arlp_pkg::POS_MAX;
        else
            value = out_mag_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_warn_reg, out_found_reg, value,
                       out_length_reg, out_status_reg};

endmodule

// ===== src/ascii_reply_line_parser.sv =====
// Reply line parser for a pan-tilt unit's serial link. Each input item is one
// received byte (s_tdata) or, with s_tuser high, a read timeout. Every line ends
// in exactly one result item: on a newline, on reaching line_limit bytes, or on
// a timeout. The result carries the status, the line length (ok status only),
// the first signed decimal number saturated to 64 bits, whether a sign or
// number was found, and the second-byte 'T'/'P' sync warning. One item is taken
// per clock unless the output stalls: a combinational classifier feeds a
// two-entry queue, and the line state unit does one multiply-by-ten-and-add
// update per clock while it pops. A result's last byte passes the queue; the
// result is held in the m_tvalid output register, so input keeps flowing while
// it waits. The user must write line_limit via line_limit_we/line_limit_wdata
// only while the block is idle; the block itself does not enforce this.
module ascii_reply_line_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        line_limit_we,
    input  logic [7:0]  line_limit_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] rx_timeout
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] reply_status, [10:3] reply_length, [74:11] number_value,
    // [76:75] number_found, [77] sync_warning, [79:78] zero
    output logic [arlp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    arlp_pkg::class_t cls;
    arlp_pkg::class_t q_data;
    logic             q_not_full;
    logic             q_valid;
    logic             q_pop;

    assign s_tready = q_not_full;

    arlp_front u_front
    (
        .rx_byte    (s_tdata),
        .rx_timeout (s_tuser),
        .cls        (cls)
    );

    arlp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && q_not_full),
        .push_data (cls),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    arlp_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .line_limit_we    (line_limit_we),
        .line_limit_wdata (line_limit_wdata),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

// ===== src/arlp_checker.sv =====
module arlp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [arlp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // Held result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Status code in range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= arlp_pkg::STATUS_TIMEOUT)
        else $error("bad reply status");

    // Length only on ok, and ok lines hold at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[2:0] == arlp_pkg::STATUS_OK) ? (m_tdata[10:3] != 8'd0)
                                                          : (m_tdata[10:3] == 8'd0)))
        else $error("length inconsistent with status");

    // No number parsed means value zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[76:75] != arlp_pkg::FOUND_NUMBER) |-> m_tdata[74:11] == 64'd0)
        else $error("value without number");

endmodule

bind ascii_reply_line_parser arlp_checker u_arlp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_ascii_reply_line_parser.sv =====
module tb_ascii_reply_line_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1150;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int GAP_MAX     = 18;

    typedef enum logic [1:0] {SCAN_SEEK, SCAN_SIGN, SCAN_DIGITS, SCAN_CLOSED} scan_phase_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       tmo;
    } rx_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  length;
        logic [63:0] value;
        logic [1:0]  found;
        logic        warn;
    } reply_t;

    logic                    clk;
    logic                    rst_n;
    logic                    line_limit_we;
    logic [7:0]              line_limit_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;   // [7:0] rx_byte
    logic                    s_tuser;   // [0] rx_timeout
    logic                    m_tvalid;
    logic                    m_tready;
    // [2:0] reply_status, [10:3] reply_length, [74:11] number_value,
    // [76:75] number_found, [77] sync_warning, [79:78] zero
    logic [arlp_pkg::OUT_TDATA_W-1:0] m_tdata;

    // stimulus and expected replies
    rx_item_t    rx_backlog[$];
    reply_t      pending_replies[$];
    int          items_queued;
    int          errors;

    // line parser state mirror
    logic [7:0]  limit_reg;
    logic [7:0]  line_cnt;
    logic        ack_seen;
    scan_phase_t scan_phase;
    logic        neg_sign;
    logic [63:0] magnitude;
    logic        warn_seen;
    logic        digits_seen;

    // driver / monitor controls
    logic        send_idle;
    logic        recv_idle;
    logic        hold_req;
    logic        hold_seen;
    int          send_gap;
    int          recv_gap;
    int          hold_cnt;
    int          quiet_cycles;
    rx_item_t    drv_item;

    ascii_reply_line_parser i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .line_limit_we    (line_limit_we),
        .line_limit_wdata (line_limit_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Line parser prediction
    // ---------------------------------------------------------------
    task automatic clear_line();
        line_cnt    = '0;
        ack_seen    = 1'b0;
        scan_phase  = SCAN_SEEK;
        neg_sign    = 1'b0;
        magnitude   = '0;
        warn_seen   = 1'b0;
        digits_seen = 1'b0;
    endtask

    // magnitude * 10 + d, saturating at 2^63
    task automatic add_digit(input logic [3:0] d);
        if (magnitude > arlp_pkg::MAG_STEP_MAX)
        begin
            magnitude = arlp_pkg::MAG_LIMIT;
        end
        else
        begin
            magnitude = magnitude * 64'd10 + 64'(d);
            if (magnitude > arlp_pkg::MAG_LIMIT)
                magnitude = arlp_pkg::MAG_LIMIT;
        end
        digits_seen = 1'b1;
    endtask

    task automatic close_line(input logic [2:0] status, input logic [7:0] length);
        reply_t r;
        r.status = status;
        r.length = length;
        if (!digits_seen)
            r.value = '0;
        else if (neg_sign)
            r.value = 64'd0 - magnitude;
        else
            r.value = (magnitude >= arlp_pkg::MAG_LIMIT) ? arlp_pkg::POS_MAX : magnitude;
        if (digits_seen)
            r.found = arlp_pkg::FOUND_NUMBER;
        else if (scan_phase != SCAN_SEEK)
            r.found = arlp_pkg::FOUND_SIGN;
        else
            r.found = arlp_pkg::FOUND_NONE;
        r.warn = warn_seen;
        pending_replies.push_back(r);
        clear_line();
    endtask

    task automatic parse_rx_item(input rx_item_t it);
        logic [7:0] c;
        logic       is_dig;
        c = it.rx;
        if (it.tmo)
        begin
            close_line(arlp_pkg::STATUS_TIMEOUT, 8'd0);
            return;
        end
        if (line_cnt != arlp_pkg::COUNT_MAX)
            line_cnt = line_cnt + 8'd1;
        if (c == arlp_pkg::CHAR_STAR)
            ack_seen = 1'b1;
        if (line_cnt == 8'd2 && (c == arlp_pkg::CHAR_T || c == arlp_pkg::CHAR_P))
            warn_seen = 1'b1;
        is_dig = (c >= arlp_pkg::CHAR_ZERO) && (c <= arlp_pkg::CHAR_NINE);

        // first-number scan
        case (scan_phase)
            SCAN_SEEK:
            begin
                if (is_dig)
                begin
                    add_digit(4'(c - arlp_pkg::CHAR_ZERO));
                    scan_phase = SCAN_DIGITS;
                end
                else if (c == arlp_pkg::CHAR_NUL)
                begin
                    scan_phase = SCAN_CLOSED;
                end
                else if (c == arlp_pkg::CHAR_MINUS || c == arlp_pkg::CHAR_PLUS)
                begin
                    neg_sign   = (c == arlp_pkg::CHAR_MINUS);
                    scan_phase = SCAN_SIGN;
                end
            end
            SCAN_SIGN, SCAN_DIGITS:
            begin
                if (is_dig)
                begin
                    add_digit(4'(c - arlp_pkg::CHAR_ZERO));
                    scan_phase = SCAN_DIGITS;
                end
                else
                begin
                    scan_phase = SCAN_CLOSED;
                end
            end
            default:
            begin
            end
        endcase

        if (c != arlp_pkg::CHAR_NEWLINE && line_cnt < limit_reg)
            return;
        // too long wins over the other line-end statuses, then too short
        if (line_cnt >= limit_reg)
            close_line(arlp_pkg::STATUS_TOO_LONG, 8'd0);
        else if (line_cnt < 8'd2)
            close_line(arlp_pkg::STATUS_TOO_SHORT, 8'd0);
        else if (ack_seen)
            close_line(arlp_pkg::STATUS_OK, line_cnt - 8'd1);
        else
            close_line(arlp_pkg::STATUS_DEV_ERR, 8'd0);
    endtask

    // ---------------------------------------------------------------
    // Driver: feeds rx_backlog into the slave side
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap = 0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            // item taken at this edge
            if (s_tvalid)
            begin
                parse_rx_item('{rx: s_tdata, tmo: s_tuser});
                send_gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
            end
            if (send_gap == 0 && rx_backlog.size() != 0)
            begin
                drv_item = rx_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_item.rx;
                s_tuser  <= drv_item.tmo;
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (send_gap != 0)
                    send_gap--;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: master side, checks each reply item
    // ---------------------------------------------------------------
    task automatic field_diff(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_reply(input logic [arlp_pkg::OUT_TDATA_W-1:0] d);
        reply_t want;
        if (pending_replies.size() == 0)
        begin
            $display("%0t: reply item with none expected, expected nothing, actual %0h",
                     $time, d);
            errors++;
            return;
        end
        want = pending_replies.pop_front();
        field_diff("reply_status", 64'(want.status), 64'(d[2:0]));
        field_diff("reply_length", 64'(want.length), 64'(d[10:3]));
        field_diff("number_value", want.value, d[74:11]);
        field_diff("number_found", 64'(want.found), 64'(d[76:75]));
        field_diff("sync_warning", 64'(want.warn), 64'(d[77]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap  = 0;
            hold_cnt  = 0;
            hold_seen = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_reply(m_tdata);
                recv_gap = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
            end
            // long hold-off requested by the sequence
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt != 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: no item moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence helpers
    // ---------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        rx_backlog.push_back('{rx: b, tmo: 1'b0});
        items_queued++;
    endtask

    task automatic push_timeout();
        rx_backlog.push_back('{rx: 8'($urandom_range(0, 255)), tmo: 1'b1});
        items_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++)
            push_byte(arlp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic write_limit(input logic [7:0] v);
        @(posedge clk);
        line_limit_we    <= 1'b1;
        line_limit_wdata <= v;
        @(posedge clk);
        line_limit_we    <= 1'b0;
        limit_reg = v;
        @(negedge clk);
    endtask

    // wait until every item went in and every reply came out
    task automatic settle();
        while (rx_backlog.size() != 0 || s_tvalid || pending_replies.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // optional sign, then usually digits; often near the 64-bit limits
    task automatic queue_number();
        int sel;
        sel = $urandom_range(0, 5);
        case ($urandom_range(0, 2))
            0: push_byte(arlp_pkg::CHAR_MINUS);
            1: push_byte(arlp_pkg::CHAR_PLUS);
            default: ;
        endcase
        case (sel)
            0: ;
            1: push_digits($urandom_range(1, 6));
            2: push_digits($urandom_range(15, 22));
            3: push_text("9223372036854775807");
            4: push_text("9223372036854775808");
            default:
            begin
                push_text("92233720368547758");
                push_digits($urandom_range(0, 3));
            end
        endcase
    endtask

    task automatic queue_reply_line();
        int kind;
        int n;
        kind = $urandom_range(0, 19);
        // noise: raw bytes of any value
        if (kind == 0)
        begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 255)));
            return;
        end
        // broken line cut short by a timeout
        if (kind == 1)
        begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(8'h20, 8'h7E)));
            push_timeout();
            return;
        end
        // mostly well-formed reply: ack, second byte, number, trailer, end
        push_byte(($urandom_range(0, 5) != 0) ? arlp_pkg::CHAR_STAR
                                               : 8'($urandom_range(8'h20, 8'h7E)));
        case ($urandom_range(0, 4))
            0: push_byte(arlp_pkg::CHAR_T);
            1: push_byte(arlp_pkg::CHAR_P);
            2: push_byte(8'h20);
            3: push_byte(arlp_pkg::CHAR_STAR);
            default: ;
        endcase
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            push_byte(($urandom_range(0, 1) != 0) ? 8'h20 : 8'h21);
        queue_number();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(8'h20, 8'h7E)));
        case ($urandom_range(0, 19))
            0, 1: push_timeout();
            2: ;
            3: push_byte(arlp_pkg::CHAR_NUL);
            default: push_byte(arlp_pkg::CHAR_NEWLINE);
        endcase
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic [7:0] limit_set[8];
        int         phase_no;
        int         phase_start;

        rst_n            <= 1'b0;
        line_limit_we    <= 1'b0;
        line_limit_wdata <= '0;
        send_idle    = 1'b0;
        recv_idle    = 1'b0;
        hold_req     = 1'b0;
        items_queued = 0;
        errors       = 0;
        limit_reg    = arlp_pkg::LINE_LIMIT_RESET;
        clear_line();
        limit_set = '{8'd255, 8'd2, 8'd12, 8'd40, 8'd200, 8'd1, 8'd0, 8'd255};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, at the reset limit
        push_text("\n");              // lone newline: too short
        push_text("!T+x\n");          // bang, sync warning, sign only, no ack
        push_text("*P-7\n");          // ok, negative number
        push_byte(arlp_pkg::CHAR_NUL); // zero byte closes the scan
        push_text("5\n");
        push_text("*9");              // timeout keeps the partial number
        push_timeout();
        push_byte(8'hFF);
        push_timeout();
        settle();

        // directed, small limits
        write_limit(8'd2);
        push_text("*\n");             // reaches limit on the newline: too long
        push_text("\n");
        settle();
        write_limit(8'd1);
        push_text("\n");
        settle();
        write_limit(8'd0);
        push_text("5x");
        settle();

        // receiver holds off while short lines keep coming
        write_limit(8'd255);
        hold_req = ~hold_req;
        for (int i = 0; i < 60; i++)
        begin
            if (i % 3 == 2)
                push_timeout();
            else
                push_text("\n");
        end
        settle();

        // random phases
        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            if (phase_no % 8 == 7)
                write_limit(8'($urandom_range(2, 255)));
            else
                write_limit(limit_set[phase_no % 8]);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            phase_start = items_queued;
            // one line long enough to hit the 255-byte limit
            if (phase_no == 0)
            begin
                push_byte(arlp_pkg::CHAR_STAR);
                for (int i = 0; i < 261; i++)
                    push_byte(8'($urandom_range(8'h20, 8'h7E)));
                push_byte(arlp_pkg::CHAR_NEWLINE);
            end
            while (items_queued - phase_start < 140)
                queue_reply_line();
            settle();
            phase_no++;
        end

        settle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/arlp_pkg.sv
src/arlp_front.sv
src/arlp_queue.sv
src/arlp_back.sv
src/ascii_reply_line_parser.sv
src/arlp_checker.sv
tb/sv/tb_ascii_reply_line_parser.sv
